[sv/vlsu_pkg.sv]
package vlsu_pkg;

    localparam int PORT_COUNT = 4;

    localparam int ADDR_W  = 32;
    localparam int REM_W   = 16;
    localparam int CNT_W   = 13;
    localparam int ELEM_W  = 12;
    localparam int SE_W    = 18;
    localparam int PORT_W  = 2;
    localparam int BYTES_W = 4;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_ISSUE = 2'd2;

    localparam logic [1:0] MODE_UNIT    = 2'd0;
    localparam logic [1:0] MODE_STRIDED = 2'd1;
    localparam logic [1:0] MODE_INDEXED = 2'd2;

    localparam logic [1:0] LANE_LOG2_RESET = 2'd3;
    localparam logic [CNT_W-1:0] MAX_ELEMS = CNT_W'(4096);

    typedef struct packed {
        logic [1:0]             opcode;
        logic [ADDR_W-1:0]      base_addr;
        logic [CNT_W-1:0]       elem_count;
        logic [ELEM_W-1:0]      vstart;
        logic [1:0]             elem_size_log2;
        logic [1:0]             mode;
        logic [ADDR_W-1:0]      stride;
        logic [3:0]             port_ready;
        logic [3:0][ADDR_W-1:0] index_offset;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] bytes;
        logic [ELEM_W-1:0]  first;
        logic               done;
    } t_res;

endpackage

[sv/vector_lsu_request_generator.sv]
// Channel   | Valid       | Ready       | Payload
// ----------+-------------+-------------+---------------------------------------------
// input     | i_in_valid  | o_in_ready  | i_opcode .. i_index_offset_3
// result    | o_out_valid | i_out_ready | o_port, o_req_addr, o_req_bytes, o_first_elem,
//           |             |             | o_write, o_insn_done, o_last
// config    | i_cfg_we    | (none)      | i_cfg_wdata (lane_width_log2)
//
// An item waits in the input register; in the cycle it leaves, all of its
// requests are formed at once and written into a result buffer with one slot per port.
// The buffer drains one request per cycle while i_out_ready is high.
// Items of up to one request flow back to back, one per cycle, while i_out_ready is high.
// Reset is synchronous and active low; the block is idle with no access in flight.
// A stall on the result side holds the buffer and, once the input register is full,
// drops o_in_ready.
module vector_lsu_request_generator
    import vlsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_wdata,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [ADDR_W-1:0]    i_base_addr,
    input  logic [CNT_W-1:0]     i_elem_count,
    input  logic [ELEM_W-1:0]    i_vstart,
    input  logic [1:0]           i_elem_size_log2,
    input  logic [1:0]           i_mode,
    input  logic signed [31:0]   i_stride,
    input  logic [3:0]           i_port_ready,
    input  logic [ADDR_W-1:0]    i_index_offset_0,
    input  logic [ADDR_W-1:0]    i_index_offset_1,
    input  logic [ADDR_W-1:0]    i_index_offset_2,
    input  logic [ADDR_W-1:0]    i_index_offset_3,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PORT_W-1:0]    o_port,
    output logic [ADDR_W-1:0]    o_req_addr,
    output logic [BYTES_W-1:0]   o_req_bytes,
    output logic [ELEM_W-1:0]    o_first_elem,
    output logic                 o_write,
    output logic                 o_insn_done,
    output logic                 o_last
);

    // Configuration.
    logic [1:0]          r_lane;

    // Input register.
    logic                r_in_valid;
    t_item               r_in;

    // Access state.
    logic [ADDR_W-1:0]   r_cur;
    logic [REM_W-1:0]    r_rem;
    logic [ELEM_W-1:0]   r_next_elem;
    logic [CNT_W-1:0]    r_total;
    logic [ADDR_W-1:0]   r_stride;
    logic [ADDR_W-1:0]   r_stride3;
    logic [1:0]          r_mode;
    logic [1:0]          r_elog2;
    logic                r_write;
    logic                r_single;
    logic [CNT_W-1:0]    r_cnt [PORT_COUNT];

    // Result buffer, one slot per port.
    logic [PORT_COUNT-1:0] r_pend;
    t_res                r_res [PORT_COUNT];
    logic                r_res_write;

    // Request formation.
    logic [3:0]          lane_b;
    logic [3:0]          esize;
    logic [1:0]          ke;
    logic [3:0]          emask;
    logic [3:0]          unit;
    logic [3:0]          step;
    logic [ADDR_W-1:0]   stride_mult [4];
    logic [SE_W-1:0]     se [PORT_COUNT];
    logic [PORT_COUNT-1:0] elig;
    logic [1:0]          rank [PORT_COUNT];
    logic [PORT_COUNT-1:0] issue;
    logic [REM_W-1:0]    rem_after [PORT_COUNT];
    t_res                res_n [PORT_COUNT];
    logic [REM_W-1:0]    last_rem;
    logic [ADDR_W-1:0]   last_addr;
    logic [BYTES_W-1:0]  last_size;
    logic [ELEM_W-1:0]   last_first;

    // Output and flow control.
    logic [PORT_W-1:0]   sel;
    logic [PORT_COUNT-1:0] pend_rest;
    logic                adv;
    logic                is_start;
    logic                is_issue;
    logic [CNT_W-1:0]    start_cnt;
    logic [1:0]          start_mode;
    logic [3:0]          start_lane_mask;

    assign lane_b = 4'd1 << r_lane;
    assign esize  = 4'd1 << r_elog2;
    assign ke     = (r_lane > r_elog2) ? r_lane - r_elog2 : 2'd0;
    assign emask  = (4'd1 << ke) - 4'd1;
    assign unit   = (r_single || r_mode != MODE_UNIT) ? esize : lane_b;
    assign step   = unit >> r_elog2;

    assign stride_mult[0] = '0;
    assign stride_mult[1] = r_stride;
    assign stride_mult[2] = r_stride << 1;
    assign stride_mult[3] = r_stride3;

    assign is_start = (r_in.opcode == OP_LOAD) || (r_in.opcode == OP_STORE);
    assign is_issue = (r_in.opcode == OP_ISSUE);

    // Eligibility and rank: a port that can issue and is preceded by k such ports takes
    // the k-th slice of the remaining access.
    always_comb begin
        logic [1:0] acc;
        acc = '0;
        for (int p = 0; p < PORT_COUNT; p++) begin
            se[p] = SE_W'((SE_W'(r_cnt[p]) >> ke) << ke) * SE_W'(PORT_COUNT)
                  + (SE_W'(p) << ke) + SE_W'(r_cnt[p] & CNT_W'(emask));
            elig[p] = is_issue && r_in.port_ready[p]
                      && (!r_single || se[p] < SE_W'(r_total));
            rank[p] = acc;
            acc     = acc + 2'(elig[p]);
        end
    end

    always_comb begin
        logic [5:0]        ku;
        logic [REM_W-1:0]  avail;
        logic [3:0]        size;
        for (int p = 0; p < PORT_COUNT; p++) begin
            ku           = 6'(unit) * 6'(rank[p]);
            avail        = r_rem - REM_W'(ku);
            issue[p]     = elig[p] && (r_rem > REM_W'(ku));
            size         = (avail < REM_W'(unit)) ? avail[3:0] : unit;
            rem_after[p] = avail - REM_W'(size);
            res_n[p].bytes = size;
            res_n[p].done  = (rem_after[p] == '0);
            if (r_single) begin
                res_n[p].addr  = r_cur + (ADDR_W'(se[p]) << r_elog2);
                res_n[p].first = r_next_elem + se[p][ELEM_W-1:0];
            end else begin
                unique case (r_mode)
                    MODE_STRIDED: res_n[p].addr = r_cur + stride_mult[rank[p]];
                    MODE_INDEXED: res_n[p].addr = r_cur + r_in.index_offset[rank[p]];
                    default:      res_n[p].addr = r_cur + ADDR_W'(ku);
                endcase
                res_n[p].first = r_next_elem + ELEM_W'(6'(step) * 6'(rank[p]));
            end
        end
    end

    // The highest issuing port carries the state left behind by this item.
    always_comb begin
        last_rem   = r_rem;
        last_addr  = r_cur;
        last_size  = '0;
        last_first = r_next_elem;
        for (int p = 0; p < PORT_COUNT; p++) begin
            if (issue[p]) begin
                last_rem   = rem_after[p];
                last_addr  = res_n[p].addr;
                last_size  = res_n[p].bytes;
                last_first = res_n[p].first;
            end
        end
    end

    always_comb begin
        sel = '0;
        for (int p = PORT_COUNT - 1; p >= 0; p--) begin
            if (r_pend[p]) begin
                sel = PORT_W'(p);
            end
        end
    end

    assign pend_rest  = r_pend & (r_pend - PORT_COUNT'(1));
    assign adv        = r_in_valid && ((r_pend == '0) || ((pend_rest == '0) && i_out_ready));
    assign o_in_ready = !r_in_valid || adv;

    assign start_cnt       = (i_elem_count > MAX_ELEMS) ? MAX_ELEMS : i_elem_count;
    assign start_mode      = (r_in.mode == 2'd3) ? MODE_UNIT : r_in.mode;
    assign start_lane_mask = lane_b - 4'd1;

    assign o_out_valid  = (r_pend != '0);
    assign o_port       = sel;
    assign o_req_addr   = r_res[sel].addr;
    assign o_req_bytes  = r_res[sel].bytes;
    assign o_first_elem = r_res[sel].first;
    assign o_insn_done  = r_res[sel].done;
    assign o_write      = r_res_write;
    assign o_last       = (pend_rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= LANE_LOG2_RESET;
        end else if (i_cfg_we) begin
            r_lane <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.opcode          <= i_opcode;
            r_in.base_addr       <= i_base_addr;
            r_in.elem_count      <= start_cnt;
            r_in.vstart          <= i_vstart;
            r_in.elem_size_log2  <= i_elem_size_log2;
            r_in.mode            <= i_mode;
            r_in.stride          <= i_stride;
            r_in.port_ready      <= i_port_ready;
            r_in.index_offset[0] <= i_index_offset_0;
            r_in.index_offset[1] <= i_index_offset_1;
            r_in.index_offset[2] <= i_index_offset_2;
            r_in.index_offset[3] <= i_index_offset_3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_rem       <= '0;
            r_next_elem <= '0;
            r_total     <= '0;
            r_stride    <= '0;
            r_stride3   <= '0;
            r_mode      <= MODE_UNIT;
            r_elog2     <= '0;
            r_write     <= 1'b0;
            r_single    <= 1'b0;
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_cnt[p] <= '0;
            end
        end else if (adv) begin
            if (is_start && r_rem == '0) begin
                // A start while requests remain is dropped.
                r_cur       <= r_in.base_addr;
                r_next_elem <= r_in.vstart;
                r_total     <= r_in.elem_count;
                r_rem       <= REM_W'(r_in.elem_count) << r_in.elem_size_log2;
                r_stride    <= r_in.stride;
                r_stride3   <= r_in.stride + (r_in.stride << 1);
                r_mode      <= start_mode;
                r_elog2     <= r_in.elem_size_log2;
                r_write     <= (r_in.opcode == OP_STORE);
                r_single    <= (start_mode == MODE_UNIT)
                               && ((r_in.base_addr[3:0] & start_lane_mask) != 4'd0);
                for (int p = 0; p < PORT_COUNT; p++) begin
                    r_cnt[p] <= '0;
                end
            end else if (issue != '0) begin
                r_rem <= last_rem;
                if (r_single) begin
                    for (int p = 0; p < PORT_COUNT; p++) begin
                        if (issue[p]) begin
                            r_cnt[p] <= r_cnt[p] + CNT_W'(1);
                        end
                    end
                end else begin
                    r_next_elem <= last_first + ELEM_W'(last_size >> r_elog2);
                    if (r_mode == MODE_STRIDED) begin
                        r_cur <= last_addr + r_stride;
                    end else if (r_mode == MODE_UNIT) begin
                        r_cur <= last_addr + ADDR_W'(last_size);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (adv) begin
            r_pend <= issue;
        end else if (o_out_valid && i_out_ready) begin
            r_pend <= pend_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res_write <= r_write;
            for (int p = 0; p < PORT_COUNT; p++) begin
                if (issue[p]) begin
                    r_res[p] <= res_n[p];
                end
            end
        end
    end

    // The final request of an access is always the final one of its item.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_insn_done) |-> o_last)
        else $error("insn_done on a request that is not the last of its item");

    // Requests of one item leave in rising port order with no gap.
    a_port_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> (o_out_valid && o_port > $past(o_port)))
        else $error("requests of one item out of port order");

    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_req_bytes != '0 && o_req_bytes <= BYTES_W'(8)))
        else $error("request byte count out of range");

    // A held input item only leaves once the result buffer is empty or draining.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_pend != '0 && !i_out_ready) |=> $stable(r_pend))
        else $error("result buffer changed while stalled");

endmodule
